>>> rtl/command_frame_receiver_macros.svh
// assertion helpers used by the frame checker
`ifndef COMMAND_FRAME_RECEIVER_MACROS_SVH
`define COMMAND_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// next-cycle implication, disabled while in reset
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

>>> rtl/cfr_pkg.sv
`default_nettype none

package cfr_pkg;

    // frame field values
    localparam logic [7:0] MAGIC_VALUE   = 8'hAC;
    localparam logic [7:0] VERSION_VALUE = 8'h01;
    localparam logic [7:0] CMD_SET       = 8'h02;
    localparam logic [7:0] CMD_PROBE     = 8'h03;
    localparam logic [7:0] TARGET_ALL    = 8'hFF;
    localparam logic [7:0] MODE_FLASH    = 8'h02;
    localparam logic [7:0] LEN_PING      = 8'd4;
    localparam logic [7:0] LEN_SET       = 8'd9;
    localparam logic [7:0] COUNT_MAX     = 8'd255;

    // header store geometry
    localparam int HDR_DEPTH = 8;
    localparam int HDR_IDX_W = 3;

    localparam int ADDR_W = 48;
    localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = {ADDR_W{1'b1}};

    // result status codes
    typedef enum logic [2:0] {
        ST_SHORT        = 3'd0,
        ST_BAD_MAGIC    = 3'd1,
        ST_BAD_VERSION  = 3'd2,
        ST_BAD_CHECKSUM = 3'd3,
        ST_PING_OK      = 3'd4,
        ST_SET_OK       = 3'd5,
        ST_OTHER_NODE   = 3'd6,
        ST_IGNORED      = 3'd7
    } status_t;

    // one registered input word
    typedef struct packed {
        logic [7:0]        frame_byte;
        logic              frame_end;
        logic [ADDR_W-1:0] sender_address;
    } frame_word_t;

    // one result word
    typedef struct packed {
        status_t           status;
        logic [7:0]        display_mode;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic              flash_start;
        logic              coordinator_known;
        logic              learned_now;
        logic [ADDR_W-1:0] coordinator_address;
    } result_t;

    // handshake between checker and the two register stages
    typedef struct packed {
        logic consume;
        logic load;
    } stage_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/cfr_frame_if.sv
`default_nettype none

interface cfr_frame_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic [47:0] sender_address;

    modport source (output valid, output frame_byte, output frame_end,
                    output sender_address, input ready);
    modport sink (input valid, input frame_byte, input frame_end,
                  input sender_address, output ready);
endinterface

`default_nettype wire

>>> rtl/cfr_result_if.sv
`default_nettype none

interface cfr_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  display_mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        flash_start;
    logic        coordinator_known;
    logic        learned_now;
    logic [47:0] coordinator_address;

    modport source (output valid, output status, output display_mode, output red,
                    output green, output blue, output flash_start,
                    output coordinator_known, output learned_now,
                    output coordinator_address, input ready);
    modport sink (input valid, input status, input display_mode, input red,
                  input green, input blue, input flash_start,
                  input coordinator_known, input learned_now,
                  input coordinator_address, output ready);
endinterface

`default_nettype wire

>>> rtl/cfr_input_stage.sv
`default_nettype none

module cfr_input_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cfr_frame_if.sink          frame_in,
    input  wire cfr_pkg::stage_ctrl_t ctrl,
    output logic               word_valid,
    output cfr_pkg::frame_word_t word
);

    logic                 word_valid_reg;
    logic                 word_valid_next;
    cfr_pkg::frame_word_t word_reg;
    logic                 take;

    // space when empty or when the held word moves on this cycle
    assign frame_in.ready = !word_valid_reg || ctrl.consume;
    assign take           = frame_in.valid && frame_in.ready;

    // occupancy
    always_comb
    begin
        if (take)
        begin
            word_valid_next = 1'b1;
        end
        else if (ctrl.consume)
        begin
            word_valid_next = 1'b0;
        end
        else
        begin
            word_valid_next = word_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
        end
        else
        begin
            word_valid_reg <= word_valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg.frame_byte     <= frame_in.frame_byte;
            word_reg.frame_end      <= frame_in.frame_end;
            word_reg.sender_address <= frame_in.sender_address;
        end
    end

    assign word_valid = word_valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

>>> rtl/cfr_frame_checker.sv
`default_nettype none

`include "command_frame_receiver_macros.svh"

module cfr_frame_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic [7:0]      cfg_wr_data,
    input  wire logic            word_valid,
    input  wire cfr_pkg::frame_word_t word,
    input  wire logic            out_free,
    output cfr_pkg::stage_ctrl_t ctrl,
    output cfr_pkg::result_t     result
);

    logic [7:0]                   node_id_reg;
    logic [7:0]                   byte_count_reg;
    logic [7:0]                   byte_count_next;
    logic [7:0]                   running_xor_reg;
    logic [7:0]                   running_xor_next;
    logic [7:0]                   header_reg [cfr_pkg::HDR_DEPTH];
    logic [7:0]                   mode_reg;
    logic [7:0]                   mode_next;
    logic [23:0]                  colour_reg;
    logic [23:0]                  colour_next;
    logic                         known_reg;
    logic                         known_next;
    logic [cfr_pkg::ADDR_W-1:0]   coordinator_reg;
    logic [cfr_pkg::ADDR_W-1:0]   coordinator_next;

    logic [7:0]                   hdr_view [cfr_pkg::HDR_DEPTH];
    logic [7:0]                   len;
    logic [7:0]                   sum;
    logic                         hdr_write;
    logic                         accept_frame;
    logic                         learned;
    logic                         flash;
    cfr_pkg::status_t             status;
    logic                         consume;

    // move the held word on; an end word needs room in the result register
    assign consume      = word_valid && (!word.frame_end || out_free);
    assign ctrl.consume = consume;
    assign ctrl.load    = consume && word.frame_end;

    // node id register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            node_id_reg <= cfg_wr_data;
        end
    end

    // header as seen with the current byte merged in
    always_comb
    begin
        for (int i = 0; i < cfr_pkg::HDR_DEPTH; i++)
        begin
            hdr_view[i] = (byte_count_reg == 8'(i)) ? word.frame_byte : header_reg[i];
        end
    end

    assign len       = (byte_count_reg == cfr_pkg::COUNT_MAX) ? cfr_pkg::COUNT_MAX
                                                              : byte_count_reg + 8'd1;
    assign sum       = running_xor_reg ^ word.frame_byte;
    assign hdr_write = (byte_count_reg[7:cfr_pkg::HDR_IDX_W] == '0);

    // frame checks in priority order
    always_comb
    begin
        accept_frame = 1'b0;
        if (len < cfr_pkg::LEN_PING)
        begin
            status = cfr_pkg::ST_SHORT;
        end
        else if (hdr_view[0] != cfr_pkg::MAGIC_VALUE)
        begin
            status = cfr_pkg::ST_BAD_MAGIC;
        end
        else if (hdr_view[1] != cfr_pkg::VERSION_VALUE)
        begin
            status = cfr_pkg::ST_BAD_VERSION;
        end
        else if (sum != 8'd0)
        begin
            status = cfr_pkg::ST_BAD_CHECKSUM;
        end
        else if (hdr_view[2] == cfr_pkg::CMD_PROBE && len == cfr_pkg::LEN_PING)
        begin
            status = cfr_pkg::ST_PING_OK;
        end
        else if (hdr_view[2] == cfr_pkg::CMD_SET && len == cfr_pkg::LEN_SET)
        begin
            if (hdr_view[3] != node_id_reg && hdr_view[3] != cfr_pkg::TARGET_ALL)
            begin
                status = cfr_pkg::ST_OTHER_NODE;
            end
            else
            begin
                status       = cfr_pkg::ST_SET_OK;
                accept_frame = 1'b1;
            end
        end
        else
        begin
            status = cfr_pkg::ST_IGNORED;
        end
    end

    // state updates from an accepted set frame, and coordinator learning on a ping
    always_comb
    begin
        mode_next        = mode_reg;
        colour_next      = colour_reg;
        known_next       = known_reg;
        coordinator_next = coordinator_reg;
        learned          = 1'b0;
        flash            = 1'b0;
        if ((status == cfr_pkg::ST_PING_OK || accept_frame) && !known_reg)
        begin
            known_next       = 1'b1;
            coordinator_next = word.sender_address;
            learned          = 1'b1;
        end
        if (accept_frame)
        begin
            mode_next   = hdr_view[4];
            colour_next = {hdr_view[5], hdr_view[6], hdr_view[7]};
            flash       = (hdr_view[4] == cfr_pkg::MODE_FLASH);
        end
    end

    // running count and checksum
    always_comb
    begin
        if (word.frame_end)
        begin
            byte_count_next  = 8'd0;
            running_xor_next = 8'd0;
        end
        else
        begin
            byte_count_next  = len;
            running_xor_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= 8'd0;
            running_xor_reg <= 8'd0;
            mode_reg        <= 8'd0;
            colour_reg      <= 24'd0;
            known_reg       <= 1'b0;
            coordinator_reg <= cfr_pkg::ADDR_ALL_ONES;
        end
        else if (consume)
        begin
            byte_count_reg  <= byte_count_next;
            running_xor_reg <= running_xor_next;
            if (word.frame_end)
            begin
                mode_reg        <= mode_next;
                colour_reg      <= colour_next;
                known_reg       <= known_next;
                coordinator_reg <= coordinator_next;
            end
        end
    end

    // header store, no reset: only entries of the current frame are read
    always_ff @(posedge clk)
    begin
        if (consume && hdr_write)
        begin
            header_reg[byte_count_reg[cfr_pkg::HDR_IDX_W-1:0]] <= word.frame_byte;
        end
    end

    // result word
    always_comb
    begin
        result.status              = status;
        result.display_mode        = mode_next;
        result.red                 = colour_next[23:16];
        result.green               = colour_next[15:8];
        result.blue                = colour_next[7:0];
        result.flash_start         = flash;
        result.coordinator_known   = known_next;
        result.learned_now         = learned;
        result.coordinator_address = coordinator_next;
    end

    `CFR_ASSERT_NOW(a_load_on_end, clk, rst_n, ctrl.load, word_valid && word.frame_end)
    `CFR_ASSERT_NOW(a_flash_is_set, clk, rst_n, ctrl.load && result.flash_start,
                    result.status == cfr_pkg::ST_SET_OK)
    `CFR_ASSERT_NOW(a_learn_on_accept, clk, rst_n, ctrl.load && result.learned_now,
                    result.coordinator_known && (result.status == cfr_pkg::ST_PING_OK ||
                    result.status == cfr_pkg::ST_SET_OK))
    `CFR_ASSERT_NEXT(a_count_clears, clk, rst_n, ctrl.load,
                     byte_count_reg == 8'd0 && running_xor_reg == 8'd0)

endmodule

`default_nettype wire

>>> rtl/cfr_output_stage.sv
`default_nettype none

module cfr_output_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cfr_pkg::stage_ctrl_t ctrl,
    input  wire cfr_pkg::result_t     result,
    output logic                 out_free,
    cfr_result_if.source         result_out
);

    logic             out_valid_reg;
    logic             out_valid_next;
    cfr_pkg::result_t result_reg;

    assign out_free = !out_valid_reg || result_out.ready;

    // occupancy
    always_comb
    begin
        if (ctrl.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            result_reg <= result;
        end
    end

    assign result_out.valid               = out_valid_reg;
    assign result_out.status              = result_reg.status;
    assign result_out.display_mode        = result_reg.display_mode;
    assign result_out.red                 = result_reg.red;
    assign result_out.green               = result_reg.green;
    assign result_out.blue                = result_reg.blue;
    assign result_out.flash_start         = result_reg.flash_start;
    assign result_out.coordinator_known   = result_reg.coordinator_known;
    assign result_out.learned_now         = result_reg.learned_now;
    assign result_out.coordinator_address = result_reg.coordinator_address;

endmodule

`default_nettype wire

>>> rtl/command_frame_receiver.sv
// a frame-end word is held in the input register and its result is loaded into the result register
// throughput: one byte per cycle, limited only by the input and result registers
// non-end bytes produce no result; a held result stalls only frame-end words
// reset (rst_n low, asynchronous): both stages empty, count and checksum zero,
// mode and colour zero, node id zero, coordinator unknown with address all ones
`default_nettype none

module command_frame_receiver (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    cfr_frame_if.sink       frame_in,
    cfr_result_if.source    result_out
);

    cfr_pkg::stage_ctrl_t ctrl;
    cfr_pkg::frame_word_t word;
    cfr_pkg::result_t     result;
    logic                 word_valid;
    logic                 out_free;

    // input register
    cfr_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_in),
        .ctrl       (ctrl),
        .word_valid (word_valid),
        .word       (word)
    );

    // per-byte tracking and frame-end decision
    cfr_frame_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .word_valid  (word_valid),
        .word        (word),
        .out_free    (out_free),
        .ctrl        (ctrl),
        .result      (result)
    );

    // result register
    cfr_output_stage u_output (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .result     (result),
        .out_free   (out_free),
        .result_out (result_out)
    );

endmodule

`default_nettype wire
